@@ rtl/periodic_event_scheduler_assert.svh @@
// Assertion macros for the periodic event scheduler; they sample on clk and are off during rst.
`ifndef PERIODIC_EVENT_SCHEDULER_ASSERT_SVH
`define PERIODIC_EVENT_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define PES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pes_pkg.sv @@
// Shared types and codes for the periodic event scheduler.
package pes_pkg;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_NEXT     = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REPLACE
  } cell_op_t;

  typedef struct packed {
    logic [31:0] due;
    logic [15:0] id;
    logic [15:0] period;
  } entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t op;
    entry_t   x;
  } cell_ctl_t;

endpackage

@@ rtl/pes_if.sv @@
// Handshake channels of the periodic event scheduler: command words in, result words out.
interface pes_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] task_id;
  logic [15:0] period;

  modport source (output valid, cmd, task_id, period, input ready);
  modport sink   (input valid, cmd, task_id, period, output ready);
endinterface

interface pes_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] due_id;
  logic [1:0]  status;

  modport source (output valid, due_id, status, input ready);
  modport sink   (input valid, due_id, status, output ready);
endinterface

@@ rtl/pes_cell.sv @@
// One cell of the sorted task chain: holds one entry and shifts toward a neighbor on update.
module pes_cell #(
  parameter int SEQ_W = 6
) (
  input  logic                  clk,
  input  pes_pkg::cell_ctl_t    ctl,
  input  logic [SEQ_W-1:0]      x_seq,
  input  logic                  valid,
  input  logic                  head,
  input  pes_pkg::entry_t       prev_ent,
  input  logic [SEQ_W-1:0]      prev_seq,
  input  logic                  prev_lt,
  input  pes_pkg::entry_t       next_ent,
  input  logic [SEQ_W-1:0]      next_seq,
  input  logic                  next_lt,
  output pes_pkg::entry_t       ent,
  output logic [SEQ_W-1:0]      seq,
  output logic                  lt
);

  pes_pkg::entry_t  ent_next;
  logic [SEQ_W-1:0] seq_next;

  // Key order: due time, then id, then registration slot.
  assign lt = valid && ({ent.due, ent.id, seq} < {ctl.x.due, ctl.x.id, x_seq});

  always_comb begin
    ent_next = ent;
    seq_next = seq;
    case (ctl.op)
      pes_pkg::CELL_INSERT: begin
        // Cells above the new key move up by one.
        if (lt) begin
          ent_next = ent;
          seq_next = seq;
        end else if (prev_lt) begin
          ent_next = ctl.x;
          seq_next = x_seq;
        end else begin
          ent_next = prev_ent;
          seq_next = prev_seq;
        end
      end
      pes_pkg::CELL_REPLACE: begin
        // Head leaves; smaller keys move down, the re-keyed entry drops in.
        if (next_lt) begin
          ent_next = next_ent;
          seq_next = next_seq;
        end else if (head || lt) begin
          ent_next = ctl.x;
          seq_next = x_seq;
        end else begin
          ent_next = ent;
          seq_next = seq;
        end
      end
      default: begin
        ent_next = ent;
        seq_next = seq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
    seq <= seq_next;
  end

endmodule

@@ rtl/periodic_event_scheduler.sv @@
// Periodic event scheduler: a sorted chain of task cells served earliest-due first.
//
// The block keeps up to CAPACITY periodic tasks in a chain of cells held in
// ascending order of (due time, id, registration slot), so the head cell is
// always the next task to serve. A register word (cmd 0) places a new task
// with first due time equal to its period; every cell compares its key with
// the new one in parallel and the cells above it move up one place. When the
// chain is full the task is dropped and the result carries status 2. A next
// word (cmd 1) reports the head's id, adds the period to its due time
// (saturating at all ones) and drops the entry back into its sorted place in
// the same cycle while the cells below it move down; on an empty chain the
// result carries status 1. A clear word (cmd 2) empties the chain and gives
// no result; cmd 3 does nothing. A new word is accepted every cycle while the
// result register is free or being read; the cost per cycle is one 32-bit add
// feeding the key compare in every cell. Results leave through a single output
// register. There is no clearing pass after reset: the fill count alone tells
// which cells hold tasks.
module periodic_event_scheduler #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  pes_in_if.sink      req,
  pes_out_if.source   rsp
);

  `include "periodic_event_scheduler_assert.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SEQ_W = $clog2(CAPACITY);

  // fill count
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  // chain wiring
  pes_pkg::entry_t    ent   [CAPACITY];
  logic [SEQ_W-1:0]   seq   [CAPACITY];
  logic               lt    [CAPACITY];
  pes_pkg::cell_ctl_t ctl;
  logic [SEQ_W-1:0]   x_seq;

  // result register
  logic               rsp_valid;
  logic [15:0]        due_id;
  pes_pkg::status_t   status;
  logic               res_load;
  logic [15:0]        res_id;
  pes_pkg::status_t   res_status;

  logic               accept;
  pes_pkg::cmd_t      cmd;
  logic [32:0]        due_sum;
  logic [31:0]        due_sat;

  assign req.ready  = !rsp_valid || rsp.ready;
  assign accept     = req.valid && req.ready;
  assign cmd        = pes_pkg::cmd_t'(req.cmd);

  assign rsp.valid  = rsp_valid;
  assign rsp.due_id = due_id;
  assign rsp.status = status;

  // next due time of the head, clamped at all ones
  assign due_sum = {1'b0, ent[0].due} + {17'd0, ent[0].period};
  assign due_sat = due_sum[32] ? '1 : due_sum[31:0];

  always_comb begin
    ctl        = '{op: pes_pkg::CELL_HOLD, x: ent[0]};
    x_seq      = seq[0];
    count_next = count;
    res_load   = 1'b0;
    res_id     = '0;
    res_status = pes_pkg::STATUS_OK;
    if (accept) begin
      case (cmd)
        pes_pkg::CMD_REGISTER: begin
          res_load = 1'b1;
          if (count < CNT_W'(CAPACITY)) begin
            ctl.op       = pes_pkg::CELL_INSERT;
            ctl.x.due    = {16'd0, req.period};
            ctl.x.id     = req.task_id;
            ctl.x.period = req.period;
            x_seq        = count[SEQ_W-1:0];
            count_next   = count + CNT_W'(1);
          end else begin
            res_status = pes_pkg::STATUS_FULL;
          end
        end
        pes_pkg::CMD_NEXT: begin
          res_load = 1'b1;
          if (count != '0) begin
            ctl.op       = pes_pkg::CELL_REPLACE;
            ctl.x.due    = due_sat;
            ctl.x.id     = ent[0].id;
            ctl.x.period = ent[0].period;
            x_seq        = seq[0];
            res_id       = ent[0].id;
          end else begin
            res_status = pes_pkg::STATUS_EMPTY;
          end
        end
        pes_pkg::CMD_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      pes_pkg::entry_t  prev_ent;
      logic [SEQ_W-1:0] prev_seq;
      logic             prev_lt;
      pes_pkg::entry_t  next_ent;
      logic [SEQ_W-1:0] next_seq;
      logic             next_lt;

      if (i == 0) begin : g_first
        assign prev_ent = ctl.x;
        assign prev_seq = x_seq;
        assign prev_lt  = 1'b1;
      end else begin : g_mid
        assign prev_ent = ent[i-1];
        assign prev_seq = seq[i-1];
        assign prev_lt  = lt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign next_ent = ent[i];
        assign next_seq = seq[i];
        assign next_lt  = 1'b0;
      end else begin : g_inner
        assign next_ent = ent[i+1];
        assign next_seq = seq[i+1];
        assign next_lt  = lt[i+1];
      end

      pes_cell #(
        .SEQ_W (SEQ_W)
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .x_seq    (x_seq),
        .valid    (count > CNT_W'(i)),
        .head     (i == 0),
        .prev_ent (prev_ent),
        .prev_seq (prev_seq),
        .prev_lt  (prev_lt),
        .next_ent (next_ent),
        .next_seq (next_seq),
        .next_lt  (next_lt),
        .ent      (ent[i]),
        .seq      (seq[i]),
        .lt       (lt[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      due_id <= res_id;
      status <= res_status;
    end
  end

  // Assertions
  `PES_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "fill count above capacity")
  `PES_ASSERT_NEXT(a_next_served, accept && cmd == pes_pkg::CMD_NEXT && count != '0, rsp_valid && status == pes_pkg::STATUS_OK && count == $past(count), "next word not served")
  `PES_ASSERT_NEXT(a_full_drop, accept && cmd == pes_pkg::CMD_REGISTER && count == CNT_W'(CAPACITY), status == pes_pkg::STATUS_FULL && count == CNT_W'(CAPACITY), "full register not dropped")
  `PES_ASSERT_NEXT(a_clear, accept && cmd == pes_pkg::CMD_CLEAR, count == '0, "clear did not empty chain")

endmodule

@@ verif/tb_periodic_event_scheduler.sv @@
// Testbench for periodic_event_scheduler: random and directed command words checked against a scoreboard.
module tb_periodic_event_scheduler;

  localparam int SLOTS = 64;
  // Cycles with no word accepted on either side before the run is declared hung.
  // The longest legal quiet stretch is the forced output hold-off below.
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int HOLD_OFF_AFTER = 120;   // results seen before the hold-off starts
  localparam int RANDOM_WORDS = 400;
  localparam int DRAIN_CYCLES = 10;
  // cmd 3 is not an operation; the block must ignore it.
  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] task_id;
    logic [15:0] period;
  } sched_word_t;

  typedef struct packed {
    logic [15:0]      due_id;
    pes_pkg::status_t status;
  } sched_reply_t;

  logic clk;
  logic rst;

  pes_in_if  req_ch ();
  pes_out_if rsp_ch ();

  periodic_event_scheduler #(
    .CAPACITY (SLOTS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Words still to be sent, and replies the scoreboard is waiting for.
  sched_word_t  cmd_backlog[$];
  sched_reply_t predicted_replies[$];

  // Scoreboard's own copy of the task store, kept in registration-slot order.
  logic [15:0] slot_id     [SLOTS];
  logic [15:0] slot_period [SLOTS];
  logic [31:0] slot_due    [SLOTS];
  int unsigned task_total;

  sched_word_t  on_offer;
  sched_reply_t oldest_reply;
  int unsigned  fail_count;
  int unsigned  results_checked;
  int unsigned  cycle_no;
  int unsigned  quiet_cycles;
  int unsigned  hold_left;
  logic         hold_done;
  logic         steady;

  // Window with no random idling on either side.
  assign steady = (cycle_no >= 400) && (cycle_no < 600);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one accepted word to the scoreboard store and queue its reply.
  // Serve order: earliest due, then smaller id, then lowest slot.
  task automatic advance_schedule(input sched_word_t w);
    sched_reply_t r;
    int unsigned  pick;
    logic [32:0]  sum;
    r.due_id = '0;
    r.status = pes_pkg::STATUS_OK;
    case (w.cmd)
      pes_pkg::CMD_REGISTER: begin
        if (task_total >= SLOTS) begin
          r.status = pes_pkg::STATUS_FULL;
        end else begin
          slot_id[task_total]     = w.task_id;
          slot_period[task_total] = w.period;
          slot_due[task_total]    = {16'd0, w.period};
          task_total++;
        end
        predicted_replies.push_back(r);
      end
      pes_pkg::CMD_NEXT: begin
        if (task_total == 0) begin
          r.status = pes_pkg::STATUS_EMPTY;
        end else begin
          pick = 0;
          for (int unsigned k = 1; k < task_total; k++) begin
            if (slot_due[k] < slot_due[pick] ||
                (slot_due[k] == slot_due[pick] && slot_id[k] < slot_id[pick]))
              pick = k;
          end
          sum = {1'b0, slot_due[pick]} + {17'd0, slot_period[pick]};
          slot_due[pick] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          r.due_id = slot_id[pick];
        end
        predicted_replies.push_back(r);
      end
      pes_pkg::CMD_CLEAR: task_total = 0;   // no reply
      default: ;                            // ignored word
    endcase
  endtask

  function automatic void queue_word(logic [1:0] c, logic [15:0] id, logic [15:0] per);
    sched_word_t w;
    w.cmd     = c;
    w.task_id = id;
    w.period  = per;
    cmd_backlog.push_back(w);
  endfunction

  // Small ids make ties on due time and id frequent; the rest spans all 16 bits.
  function automatic logic [15:0] random_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 16'($urandom_range(0, 7));
    if (r < 50) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Short periods keep due times close together; zero and all ones show up too.
  function automatic logic [15:0] random_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'h0000;
    if (r < 10) return 16'hFFFF;
    if (r < 70) return 16'($urandom_range(1, 16));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Driver: holds a word until it is taken, then offers the next one or idles.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        advance_schedule(on_offer);
      if (!req_ch.valid || req_ch.ready) begin
        if (cmd_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 24)) begin
          on_offer = cmd_backlog.pop_front();
          req_ch.valid   <= 1'b1;
          req_ch.cmd     <= on_offer.cmd;
          req_ch.task_id <= on_offer.task_id;
          req_ch.period  <= on_offer.period;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result-side ready: random stalls, plus one long hold-off so the output
  // register stays full and the block has to stop taking words.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && results_checked >= HOLD_OFF_AFTER) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= HOLD_OFF_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 24);
    end
  end

  // Monitor: every reply taken must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (predicted_replies.size() == 0) begin
        $error("unexpected reply: due_id %0d status %0d", rsp_ch.due_id, rsp_ch.status);
        fail_count++;
      end else begin
        oldest_reply = predicted_replies.pop_front();
        if (rsp_ch.due_id !== oldest_reply.due_id) begin
          $error("due_id mismatch: expected %0d, actual %0d",
                 oldest_reply.due_id, rsp_ch.due_id);
          fail_count++;
        end
        if (rsp_ch.status !== oldest_reply.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 oldest_reply.status, rsp_ch.status);
          fail_count++;
        end
      end
      results_checked <= results_checked + 1;
    end
  end

  // Watchdog on handshake progress.
  always @(posedge clk) begin
    if (rst) begin
      cycle_no     <= 0;
      quiet_cycles <= 0;
    end else begin
      cycle_no <= cycle_no + 1;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_words;
    int unsigned burst;
    int unsigned ops;
    int unsigned r;

    // Known values on every block input from time zero.
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.cmd     = pes_pkg::CMD_REGISTER;
    req_ch.task_id = '0;
    req_ch.period  = '0;
    rsp_ch.ready   = 1'b0;
    on_offer       = '0;
    task_total     = 0;
    fail_count     = 0;
    results_checked = 0;

    // Directed words.
    queue_word(pes_pkg::CMD_NEXT, 16'h1234, 16'h0042);      // serve on an empty store
    queue_word(pes_pkg::CMD_REGISTER, 16'h0000, 16'h0001);  // smallest id, shortest period
    queue_word(pes_pkg::CMD_REGISTER, 16'hFFFF, 16'hFFFF);  // largest id and period
    queue_word(pes_pkg::CMD_REGISTER, 16'd7, 16'd10);
    queue_word(pes_pkg::CMD_REGISTER, 16'd3, 16'd10);       // same due, smaller id wins
    queue_word(pes_pkg::CMD_REGISTER, 16'd3, 16'd10);       // same due and id: earlier slot
    queue_word(CMD_NOP, 16'hFFFF, 16'hFFFF);                // ignored
    queue_word(pes_pkg::CMD_NEXT, 16'h0000, 16'h0000);
    queue_word(pes_pkg::CMD_NEXT, 16'hFFFF, 16'hFFFF);
    queue_word(pes_pkg::CMD_NEXT, 16'h0000, 16'h0000);
    queue_word(pes_pkg::CMD_NEXT, 16'h0000, 16'h0000);
    queue_word(pes_pkg::CMD_REGISTER, 16'd5, 16'd0);        // zero period: due never moves
    queue_word(pes_pkg::CMD_NEXT, 16'h0000, 16'h0000);
    queue_word(pes_pkg::CMD_NEXT, 16'h0000, 16'h0000);
    queue_word(pes_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF);
    queue_word(pes_pkg::CMD_NEXT, 16'h0000, 16'h0000);      // empty again after clear
    queue_word(pes_pkg::CMD_REGISTER, 16'h8000, 16'h8000);
    queue_word(pes_pkg::CMD_NEXT, 16'h5555, 16'hAAAA);
    queue_word(CMD_NOP, 16'h0000, 16'h0000);
    queue_word(pes_pkg::CMD_CLEAR, 16'h0000, 16'h0000);

    // Random part: a clear, a burst of registers (a quarter of the time 60 to 68,
    // which can overfill the 64-slot store), then a mix dominated by serves.
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      queue_word(pes_pkg::CMD_CLEAR, random_id(), random_period());
      random_words++;
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 12);
      repeat (burst) begin
        queue_word(pes_pkg::CMD_REGISTER, random_id(), random_period());
        random_words++;
      end
      ops = $urandom_range(5, 30);
      repeat (ops) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          queue_word(pes_pkg::CMD_NEXT, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)));
          random_words++;
        end else if (r < 85) begin
          queue_word(pes_pkg::CMD_REGISTER, random_id(), random_period());
          random_words++;
        end else if (r < 93) begin
          queue_word(CMD_NOP, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end else begin
          queue_word(pes_pkg::CMD_CLEAR, random_id(), random_period());
          random_words++;
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Drain: every word sent, every reply back, then a short settle.
    while (cmd_backlog.size() != 0 || req_ch.valid)
      @(posedge clk);
    while (predicted_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pes_pkg.sv
rtl/pes_if.sv
rtl/pes_cell.sv
rtl/periodic_event_scheduler.sv
verif/tb_periodic_event_scheduler.sv
